>>> design/fat_cluster_chain_engine_core_defines.svh
// ----------------------------------------------------------------------------
// fat_cluster_chain_engine_core assertion macros
// Clocked, reset-gated property wrappers used by the top level.
// ----------------------------------------------------------------------------
`ifndef FAT_CLUSTER_CHAIN_ENGINE_CORE_DEFINES_SVH
`define FAT_CLUSTER_CHAIN_ENGINE_CORE_DEFINES_SVH

// same-cycle implication
`define FCCE_ASSERT_NOW(label, ante, cons, msg) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) \
        (ante) |-> (cons)) else $error(msg);

// next-cycle implication
`define FCCE_ASSERT_NEXT(label, ante, cons, msg) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) \
        (ante) |=> (cons)) else $error(msg);

`endif

>>> design/fcce_pkg.sv
// ----------------------------------------------------------------------------
// fcce_pkg
// Shared types and codes of the FAT cluster chain engine.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

package fcce_pkg;

    // operation codes
    localparam logic [1:0] OP_WRITE  = 2'd0;
    localparam logic [1:0] OP_NEXT   = 2'd1;
    localparam logic [1:0] OP_FIND   = 2'd2;
    localparam logic [1:0] OP_EXTEND = 2'd3;

    // status codes
    localparam logic [1:0] ST_OK       = 2'd0;
    localparam logic [1:0] ST_NOT_END  = 2'd1;
    localparam logic [1:0] ST_NO_FREE  = 2'd2;
    localparam logic [1:0] ST_RANGE    = 2'd3;

    // configuration register indexes
    localparam logic [1:0] CFG_ENTRY_COUNT = 2'd0;
    localparam logic [1:0] CFG_DATA_START  = 2'd1;
    localparam logic [1:0] CFG_ROOT        = 2'd2;
    localparam logic [1:0] CFG_SPC         = 2'd3;

    typedef struct packed {
        logic [12:0] entry_count;
        logic [31:0] data_start_sector;
        logic [27:0] root_cluster;
        logic [7:0]  sector_mult;
    } t_cfg;

endpackage

`default_nettype wire

>>> design/fat_cluster_chain_engine_core.sv
// ----------------------------------------------------------------------------
// fat_cluster_chain_engine_core
// FAT32 allocation table engine: load, follow, find free, extend chain.
// ----------------------------------------------------------------------------
// channel   dir  handshake                  payload
// s_axis    in   s_axis_tvalid/tready       tuser operation, tdata index+value
// m_axis    out  m_axis_tvalid/tready       tuser status, tdata cluster+sector
// cfg       in   i_cfg_valid/o_cfg_ready    i_cfg_index, i_cfg_data
//
// One item at a time. Write entry and out-of-range items pass through S_MUL
// and S_OUT; next cluster and the end-of-chain check read the entry in S_RD first.
// Find free and extend scan entries from cluster 2 upward in S_SCAN; extend then
// links the chain in S_LINK1 and S_LINK2. A fruitless search stops at the limit.
// The table RAM has a single read port: the search reads one entry
// per cycle.
// Reset clears control and config only; table contents are undefined.
// Output register lets the next beat be accepted while a result waits; the
// following result then holds in S_OUT, and the input with it, until it drains.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none
`include "fat_cluster_chain_engine_core_defines.svh"

module fat_cluster_chain_engine_core #(
    parameter int TABLE_ENTRIES = 4096,
    parameter int END_MARK      = 268435455
) (
    input  wire logic          i_clk,
    input  wire logic          i_rst_n,
    // input items
    input  wire logic          s_axis_tvalid,
    output logic               s_axis_tready,
    input  wire logic [1:0]    s_axis_tuser,   // [1:0] operation
    input  wire logic [47:0]   s_axis_tdata,   // [11:0] entry_index, [43:12] entry_value
    // results
    output logic               m_axis_tvalid,
    input  wire logic          m_axis_tready,
    output logic      [1:0]    m_axis_tuser,   // [1:0] status
    output logic      [63:0]   m_axis_tdata,   // [27:0] cluster_out, [59:28] first_sector
    // configuration writes
    input  wire logic          i_cfg_valid,
    output logic               o_cfg_ready,
    input  wire logic [1:0]    i_cfg_index,
    input  wire logic [31:0]   i_cfg_data
);
    import fcce_pkg::*;

    localparam int AW = $clog2(TABLE_ENTRIES);
    localparam int LW = (AW >= 13) ? AW + 1 : 13;
    localparam logic [LW-1:0] TE_L     = LW'(TABLE_ENTRIES);
    localparam logic [27:0]   END_W    = 28'(END_MARK);
    localparam logic [LW-1:0] SCAN_LO  = LW'(2);

    localparam logic [2:0] S_IDLE  = 3'd0;
    localparam logic [2:0] S_RD    = 3'd1;
    localparam logic [2:0] S_SCAN  = 3'd2;
    localparam logic [2:0] S_LINK1 = 3'd3;
    localparam logic [2:0] S_LINK2 = 3'd4;
    localparam logic [2:0] S_MUL   = 3'd5;
    localparam logic [2:0] S_OUT   = 3'd6;

    t_cfg w_cfg;

    logic [2:0]    r_state;
    logic [1:0]    r_op;
    logic [AW-1:0] r_idx;
    logic [31:0]   r_val;
    logic [27:0]   r_cluster;
    logic [1:0]    r_status;
    logic [LW-1:0] r_scan;
    logic          r_chk_valid;
    logic [LW-1:0] r_chk_idx;

    logic          r_out_valid;
    logic [1:0]    r_out_status;
    logic [27:0]   r_out_cluster;
    logic [31:0]   r_out_sector;

    logic          w_in_acc;
    logic [1:0]    w_in_op;
    logic [LW-1:0] w_in_idx;
    logic [AW-1:0] w_in_addr;
    logic          w_in_range;
    logic [LW-1:0] w_limit;
    logic          w_hit;
    logic          w_out_load;

    logic          w_we;
    logic [AW-1:0] w_waddr;
    logic [31:0]   w_wdata;
    logic [AW-1:0] w_raddr;
    logic [31:0]   w_rdata;
    logic [31:0]   w_sector;

    fcce_cfg u_cfg (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg_valid (i_cfg_valid),
        .o_cfg_ready (o_cfg_ready),
        .i_cfg_index (i_cfg_index),
        .i_cfg_data  (i_cfg_data),
        .o_cfg       (w_cfg)
    );

    fcce_ram #(
        .WIDTH (32),
        .DEPTH (TABLE_ENTRIES)
    ) u_table (
        .i_clk   (i_clk),
        .i_we    (w_we),
        .i_waddr (w_waddr),
        .i_wdata (w_wdata),
        .i_raddr (w_raddr),
        .o_rdata (w_rdata)
    );

    fcce_sector u_sector (
        .i_clk     (i_clk),
        .i_cluster (r_cluster),
        .i_cfg     (w_cfg),
        .o_sector  (w_sector)
    );

    assign s_axis_tready = (r_state == S_IDLE);
    assign w_in_acc      = s_axis_tvalid && s_axis_tready;
    assign w_in_op       = s_axis_tuser;
    assign w_in_idx      = LW'(s_axis_tdata[11:0]);
    assign w_in_addr     = w_in_idx[AW-1:0];

    assign w_limit    = (LW'(w_cfg.entry_count) < TE_L) ? LW'(w_cfg.entry_count) : TE_L;
    assign w_in_range = (w_in_idx < w_limit);

    // the read issued last cycle is the one under test now
    assign w_hit = r_chk_valid && (w_rdata[27:0] == 28'd0);

    assign w_out_load = (r_state == S_OUT) && (!r_out_valid || m_axis_tready);

    // Table port steering. In IDLE a write item writes and reads the same entry
    // in one cycle; that read data is never used.
    always_comb begin
        w_we    = 1'b0;
        w_waddr = r_idx;
        w_wdata = r_val;
        w_raddr = w_in_addr;
        case (r_state)
            S_IDLE: begin
                if (w_in_acc && w_in_op == OP_WRITE && w_in_range) begin
                    w_we    = 1'b1;
                    w_waddr = w_in_addr;
                    w_wdata = s_axis_tdata[43:12];
                end
            end
            S_SCAN: begin
                w_raddr = r_scan[AW-1:0];
            end
            S_LINK1: begin
                w_we    = 1'b1;
                w_wdata = {r_val[31:28], r_cluster};
            end
            S_LINK2: begin
                w_we    = 1'b1;
                w_waddr = r_cluster[AW-1:0];
                w_wdata = 32'hFFFF_FFFF;
            end
            default: ;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_chk_valid <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            if (w_out_load) begin
                r_out_valid <= 1'b1;
            end else if (m_axis_tvalid && m_axis_tready) begin
                r_out_valid <= 1'b0;
            end
            case (r_state)
                S_IDLE: begin
                    if (w_in_acc) begin
                        r_op        <= w_in_op;
                        r_idx       <= w_in_addr;
                        r_cluster   <= 28'd0;
                        r_status    <= ST_OK;
                        r_scan      <= SCAN_LO;
                        r_chk_valid <= 1'b0;
                        if (w_in_op == OP_FIND) begin
                            r_state <= S_SCAN;
                        end else if (!w_in_range) begin
                            r_status <= ST_RANGE;
                            r_state  <= S_MUL;
                        end else if (w_in_op == OP_WRITE) begin
                            r_state <= S_MUL;
                        end else begin
                            r_state <= S_RD;
                        end
                    end
                end
                S_RD: begin
                    r_val <= w_rdata;
                    if (r_op == OP_NEXT) begin
                        r_cluster <= w_rdata[27:0];
                        r_state   <= S_MUL;
                    end else if (w_rdata[27:0] != END_W) begin
                        r_status <= ST_NOT_END;
                        r_state  <= S_MUL;
                    end else begin
                        r_state <= S_SCAN;
                    end
                end
                S_SCAN: begin
                    if (w_hit) begin
                        r_chk_valid <= 1'b0;
                        r_cluster   <= 28'(r_chk_idx);
                        r_state     <= (r_op == OP_FIND) ? S_MUL : S_LINK1;
                    end else if (r_scan >= w_limit) begin
                        // last outstanding read missed and nothing left to issue
                        r_chk_valid <= 1'b0;
                        r_status    <= ST_NO_FREE;
                        r_state     <= S_MUL;
                    end else begin
                        r_chk_valid <= 1'b1;
                        r_chk_idx   <= r_scan;
                        r_scan      <= r_scan + 1'b1;
                    end
                end
                S_LINK1: begin
                    r_state <= S_LINK2;
                end
                S_LINK2: begin
                    r_state <= S_MUL;
                end
                S_MUL: begin
                    r_state <= S_OUT;
                end
                S_OUT: begin
                    if (w_out_load) begin
                        r_out_status  <= r_status;
                        r_out_cluster <= r_cluster;
                        r_out_sector  <= (r_status == ST_OK && r_op != OP_WRITE) ?
                                         w_sector : 32'd0;
                        r_state       <= S_IDLE;
                    end
                end
                default: begin
                    r_state <= S_IDLE;
                end
            endcase
        end
    end

    assign m_axis_tvalid = r_out_valid;
    assign m_axis_tuser  = r_out_status;
    assign m_axis_tdata  = {4'd0, r_out_sector, r_out_cluster};

    `FCCE_ASSERT_NOW(a_write_states, w_we,
        (r_state == S_IDLE || r_state == S_LINK1 || r_state == S_LINK2),
        "table write outside a write state")
    `FCCE_ASSERT_NEXT(a_accept_leaves_idle, w_in_acc, (r_state != S_IDLE),
        "accepted beat did not start work")
    `FCCE_ASSERT_NOW(a_free_in_range, (r_state == S_SCAN && w_hit),
        (r_chk_idx >= SCAN_LO && r_chk_idx < w_limit),
        "free cluster outside search window")
    `FCCE_ASSERT_NOW(a_error_no_cluster, (r_out_valid && r_out_status != ST_OK),
        (r_out_cluster == 28'd0 && r_out_sector == 32'd0),
        "error result carries a cluster")

endmodule

`default_nettype wire

>>> design/fcce_ram.sv
// ----------------------------------------------------------------------------
// fcce_ram
// Generic simple dual-port RAM, one write port, one registered read port.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module fcce_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 4096
) (
    input  wire logic                     i_clk,
    input  wire logic                     i_we,
    input  wire logic [$clog2(DEPTH)-1:0] i_waddr,
    input  wire logic [WIDTH-1:0]         i_wdata,
    input  wire logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic      [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        o_rdata <= r_mem[i_raddr];
    end

endmodule

`default_nettype wire

>>> design/fcce_cfg.sv
// ----------------------------------------------------------------------------
// fcce_cfg
// Configuration register bank with its write channel.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module fcce_cfg (
    input  wire logic          i_clk,
    input  wire logic          i_rst_n,
    input  wire logic          i_cfg_valid,
    output logic               o_cfg_ready,
    input  wire logic [1:0]    i_cfg_index,
    input  wire logic [31:0]   i_cfg_data,
    output fcce_pkg::t_cfg     o_cfg
);
    import fcce_pkg::*;

    t_cfg r_cfg;

    assign o_cfg_ready = 1'b1;
    assign o_cfg       = r_cfg;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.entry_count         <= 13'd4096;
            r_cfg.data_start_sector   <= 32'd0;
            r_cfg.root_cluster        <= 28'd2;
            r_cfg.sector_mult         <= 8'd8;
        end else if (i_cfg_valid) begin
            case (i_cfg_index)
                CFG_ENTRY_COUNT: r_cfg.entry_count         <= i_cfg_data[12:0];
                CFG_DATA_START:  r_cfg.data_start_sector   <= i_cfg_data;
                CFG_ROOT:        r_cfg.root_cluster        <= i_cfg_data[27:0];
                CFG_SPC:         r_cfg.sector_mult         <= i_cfg_data[7:0];
                default: ;
            endcase
        end
    end

endmodule

`default_nettype wire

>>> design/fcce_sector.sv
// ----------------------------------------------------------------------------
// fcce_sector
// Cluster to first sector mapping, multiply registered, add after it.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module fcce_sector (
    input  wire logic          i_clk,
    input  wire logic [27:0]   i_cluster,
    input  wire fcce_pkg::t_cfg i_cfg,
    output logic      [31:0]   o_sector
);
    import fcce_pkg::*;

    logic [31:0] w_diff;
    logic [39:0] w_prod;
    logic [31:0] r_prod;

    // offset wraps modulo 2^32 like the cluster arithmetic it models
    assign w_diff = {4'd0, i_cluster} - {4'd0, i_cfg.root_cluster};
    assign w_prod = w_diff * i_cfg.sector_mult;

    always_ff @(posedge i_clk) begin
        r_prod <= w_prod[31:0];
    end

    assign o_sector = i_cfg.data_start_sector + r_prod;

endmodule

`default_nettype wire
